/* rtl/gpf_pkg.sv */
// Shared constants, types and datapath step functions of the pairwise gravity force block.
package gpf_pkg;

  // Fixed-point formats.
  localparam int POS_FRAC_BITS = 16;
  localparam int GRAV_SHIFT    = 32;

  // Field widths.
  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int GRAV_W  = 32;
  localparam int FORCE_W = 48;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_GRAV_CONST = 1'b0;

  // Datapath widths.
  localparam int MAG_W     = POS_W;
  localparam int SUM_W     = 2 * MAG_W + 1;
  localparam int ROOT_W    = (SUM_W + 1) / 2;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int P_W       = GRAV_W + 2 * MASS_W;
  localparam int N_W       = P_W + MAG_W;
  localparam int D_W       = SUM_W + ROOT_W;
  localparam int Q_BITS    = FORCE_W - 1;
  localparam int NUM_SHIFT = 3 * POS_FRAC_BITS - GRAV_SHIFT;
  localparam int NX_SHIFT  = Q_BITS - NUM_SHIFT;
  localparam int HI_W      = N_W - NX_SHIFT;

  // Values that ride alongside the square root.
  typedef struct packed {
    logic [P_W-1:0]   p;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic             negx;
    logic             negy;
    logic             coinc;
  } gpf_side_t;

  // Partial root and remainder of the digit-by-digit square root.
  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sq_state_t;

  // One axis of the long division.
  typedef struct packed {
    logic [D_W-1:0]    rem;
    logic [Q_BITS-1:0] low;
    logic [Q_BITS-1:0] q;
    logic              sat;
    logic              neg;
  } div_lane_t;

  // One root bit: bring down a pair of radicand bits and try 4*root+1.
  function automatic sq_state_t sqrt_step(sq_state_t st, logic [1:0] pair);
    logic [SQ_REM_W+1:0] acc;
    logic [SQ_REM_W+1:0] trial;
    sq_state_t           r;
    acc   = {st.rem, pair};
    trial = {{(SQ_REM_W - ROOT_W){1'b0}}, st.root, 2'b01};
    if (acc >= trial) begin
      r.rem  = SQ_REM_W'(acc - trial);
      r.root = {st.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc[SQ_REM_W-1:0];
      r.root = {st.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Set up one axis: the top numerator bits form the first remainder.
  function automatic div_lane_t div_init(logic [N_W-1:0] n, logic neg, logic [D_W-1:0] d);
    logic [HI_W-1:0] hi;
    div_lane_t       l;
    hi    = n[N_W-1:NX_SHIFT];
    l.sat = (D_W'(hi) >= d);
    l.rem = D_W'(hi);
    l.low = {n[NX_SHIFT-1:0], {NUM_SHIFT{1'b0}}};
    l.q   = '0;
    l.neg = neg;
    return l;
  endfunction

  // One quotient bit of restoring division.
  function automatic div_lane_t div_step(div_lane_t l, int unsigned k, logic [D_W-1:0] d);
    logic [D_W:0] acc;
    div_lane_t    r;
    r   = l;
    acc = {l.rem, l.low[Q_BITS-1-k]};
    if (acc >= {1'b0, d}) begin
      r.rem = D_W'(acc - {1'b0, d});
      r.q   = {l.q[Q_BITS-2:0], 1'b1};
    end else begin
      r.rem = acc[D_W-1:0];
      r.q   = {l.q[Q_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  // Apply the sign, saturate, and zero the force for coincident bodies.
  function automatic logic [FORCE_W-1:0] force_out(div_lane_t l, logic coinc);
    logic [FORCE_W-1:0] f;
    if (coinc) begin
      f = '0;
    end else if (l.sat) begin
      f = l.neg ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, {Q_BITS{1'b1}}};
    end else begin
      f = l.neg ? FORCE_W'(-{1'b0, l.q}) : {1'b0, l.q};
    end
    return f;
  endfunction

endpackage

/* rtl/gpf_pair_if.sv */
// Stream interface that carries one body pair per beat.
interface gpf_pair_if import gpf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  src_x;
  logic signed [POS_W-1:0]  src_y;
  logic        [MASS_W-1:0] src_mass;
  logic signed [POS_W-1:0]  tgt_x;
  logic signed [POS_W-1:0]  tgt_y;
  logic        [MASS_W-1:0] tgt_mass;
  logic                     is_source;

  modport source (output valid, src_x, src_y, src_mass, tgt_x, tgt_y, tgt_mass, is_source,
                  input ready);
  modport sink (input valid, src_x, src_y, src_mass, tgt_x, tgt_y, tgt_mass, is_source,
                output ready);
endinterface

/* rtl/gpf_force_if.sv */
// Stream interface that carries one force result per beat.
interface gpf_force_if import gpf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  logic                      coincident;

  modport source (output valid, force_x, force_y, coincident, input ready);
  modport sink (input valid, force_x, force_y, coincident, output ready);
endinterface

/* rtl/gravity_pair_force_top.sv */
// Pairwise Newtonian gravity force engine: top level.
//
// Body pairs arrive on the req stream, one pair per beat; the force on the
// target toward the source leaves on the rsp stream, one result per beat.
// A pair marked is_source produces no result; coincident positions give a
// zero force with coincident set. Forces saturate to 48 signed bits.
// The gravitational constant is written over the APB port at address 0.
//
// Throughput is one pair per cycle while the output is not stalled. The
// pipeline holds 87 register stages: 3 stages of differences, squares
// and mass products, 33 square root stages (one root bit each), 2 stages
// of wide products, and 49 divider stages (setup, 47 quotient bits,
// output).
//
// The whole pipeline advances together. While a result waits at the output
// and rsp.ready is low, req.ready is low and every stage holds its contents.
// Reset (rst, synchronous) empties the pipeline and sets the constant to 1.
module gravity_pair_force_top import gpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  gpf_pair_if.sink              req,
  gpf_force_if.source           rsp
);

  logic [GRAV_W-1:0] grav_const;
  logic              en;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_const <= GRAV_W'(1);
    end else if (psel && penable && pwrite && (paddr[2] == CFG_GRAV_CONST)) begin
      grav_const <= pwdata[GRAV_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_GRAV_CONST) ? CFG_DATA_W'(grav_const) : '0;

  // Global advance: the output register is free or being taken.
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Stage 1: position differences and the first mass product.
  logic signed [POS_W:0] dx_c;
  logic signed [POS_W:0] dy_c;
  logic                  v1;
  logic [MAG_W-1:0]      ax1, ay1;
  logic                  negx1, negy1, coinc1;
  logic [2*GRAV_W-1:0]   gm1;
  logic [MASS_W-1:0]     m2_1;

  assign dx_c = {req.src_x[POS_W-1], req.src_x} - {req.tgt_x[POS_W-1], req.tgt_x};
  assign dy_c = {req.src_y[POS_W-1], req.src_y} - {req.tgt_y[POS_W-1], req.tgt_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid && !req.is_source;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1    <= dx_c[POS_W] ? MAG_W'(-dx_c) : dx_c[MAG_W-1:0];
      ay1    <= dy_c[POS_W] ? MAG_W'(-dy_c) : dy_c[MAG_W-1:0];
      negx1  <= dx_c[POS_W];
      negy1  <= dy_c[POS_W];
      coinc1 <= (req.src_x == req.tgt_x) && (req.src_y == req.tgt_y);
      gm1    <= (2*GRAV_W)'(grav_const) * (2*GRAV_W)'(req.src_mass);
      m2_1   <= req.tgt_mass;
    end
  end

  // Stage 2: squares and the partial products of the full mass term.
  logic                     v2;
  logic [2*MAG_W-1:0]       sqx2, sqy2;
  logic [GRAV_W+MASS_W-1:0] pl2, ph2;
  logic [MAG_W-1:0]         ax2, ay2;
  logic                     negx2, negy2, coinc2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2   <= (2*MAG_W)'(ax1) * (2*MAG_W)'(ax1);
      sqy2   <= (2*MAG_W)'(ay1) * (2*MAG_W)'(ay1);
      pl2    <= (GRAV_W+MASS_W)'(gm1[GRAV_W-1:0]) * (GRAV_W+MASS_W)'(m2_1);
      ph2    <= (GRAV_W+MASS_W)'(gm1[2*GRAV_W-1:GRAV_W]) * (GRAV_W+MASS_W)'(m2_1);
      ax2    <= ax1;
      ay2    <= ay1;
      negx2  <= negx1;
      negy2  <= negy1;
      coinc2 <= coinc1;
    end
  end

  // Stage 3: squared distance and the full mass term.
  logic             v3;
  logic [SUM_W-1:0] sum3;
  gpf_side_t        side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3       <= SUM_W'(sqx2) + SUM_W'(sqy2);
      side3.p    <= P_W'(pl2) + P_W'({ph2, {GRAV_W{1'b0}}});
      side3.ax   <= ax2;
      side3.ay   <= ay2;
      side3.negx <= negx2;
      side3.negy <= negy2;
      side3.coinc <= coinc2;
    end
  end

  // Square root of the squared distance.
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [SUM_W-1:0]  sq_sum;
  gpf_side_t         sq_side;

  gpf_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_sum    (sum3),
    .in_side   (side3),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_sum   (sq_sum),
    .out_side  (sq_side)
  );

  // Stage 4: partial products of the denominator and both numerators.
  localparam int DL_W = MAG_W + ROOT_W;
  localparam int DH_W = SUM_W - MAG_W + ROOT_W;
  localparam int PX_W = 2 * MAG_W;

  logic            v4;
  logic [DL_W-1:0] dl4;
  logic [DH_W-1:0] dh4;
  logic [PX_W-1:0] px4 [0:2];
  logic [PX_W-1:0] py4 [0:2];
  logic            negx4, negy4, coinc4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl4    <= DL_W'(sq_sum[MAG_W-1:0]) * DL_W'(sq_root);
      dh4    <= DH_W'(sq_sum[SUM_W-1:MAG_W]) * DH_W'(sq_root);
      negx4  <= sq_side.negx;
      negy4  <= sq_side.negy;
      coinc4 <= sq_side.coinc;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_np
    always_ff @(posedge clk) begin
      if (en) begin
        px4[i] <= PX_W'(sq_side.p[MAG_W*i +: MAG_W]) * PX_W'(sq_side.ax);
        py4[i] <= PX_W'(sq_side.p[MAG_W*i +: MAG_W]) * PX_W'(sq_side.ay);
      end
    end
  end

  // Stage 5: denominator and numerators summed.
  logic           v5;
  logic [D_W-1:0] d5;
  logic [N_W-1:0] nx5, ny5;
  logic           negx5, negy5, coinc5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d5     <= D_W'(dl4) + D_W'({dh4, {MAG_W{1'b0}}});
      nx5    <= N_W'(px4[0]) + N_W'({px4[1], {MAG_W{1'b0}}})
                + N_W'({px4[2], {(2*MAG_W){1'b0}}});
      ny5    <= N_W'(py4[0]) + N_W'({py4[1], {MAG_W{1'b0}}})
                + N_W'({py4[2], {(2*MAG_W){1'b0}}});
      negx5  <= negx4;
      negy5  <= negy4;
      coinc5 <= coinc4;
    end
  end

  // Division, saturation and output register.
  logic               out_valid;
  logic [FORCE_W-1:0] out_fx, out_fy;
  logic               out_coinc;

  gpf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_nx     (nx5),
    .in_ny     (ny5),
    .in_d      (d5),
    .in_negx   (negx5),
    .in_negy   (negy5),
    .in_coinc  (coinc5),
    .out_valid (out_valid),
    .out_fx    (out_fx),
    .out_fy    (out_fy),
    .out_coinc (out_coinc)
  );

  assign rsp.valid      = out_valid;
  assign rsp.force_x    = out_fx;
  assign rsp.force_y    = out_fy;
  assign rsp.coincident = out_coinc;

  // A coincident result always reports zero force.
  a_coinc_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.coincident |-> (rsp.force_x == '0) && (rsp.force_y == '0))
    else $error("coincident result with nonzero force");

  // A pair marked as the source never enters the pipeline.
  a_source_dropped: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.is_source |=> !v1)
    else $error("source pair entered the pipeline");

  // A stalled output freezes the input side.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("input accepted while output stalled");

endmodule

/* rtl/gpf_sqrt.sv */
// Pipelined integer square root, one root bit per stage, with a sideband.
module gpf_sqrt import gpf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  gpf_side_t         in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SUM_W-1:0]  out_sum,
  output gpf_side_t         out_side
);

  logic             vld  [0:ROOT_W];
  sq_state_t        st   [0:ROOT_W];
  logic [SUM_W-1:0] sum  [0:ROOT_W];
  gpf_side_t        side [0:ROOT_W];

  // Stage zero is the input itself.
  assign vld[0]  = in_valid;
  assign st[0]   = '0;
  assign sum[0]  = in_sum;
  assign side[0] = in_side;

  // One stage for each root bit, most significant first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [2*ROOT_W-1:0] pad;
    assign pad = {{(2 * ROOT_W - SUM_W){1'b0}}, sum[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1]   <= sqrt_step(st[k], pad[2*ROOT_W-1-2*k -: 2]);
        sum[k+1]  <= sum[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = st[ROOT_W].root;
  assign out_sum   = sum[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

/* rtl/gpf_div.sv */
// Pipelined two-axis divider with sign, saturation and coincidence handling.
module gpf_div import gpf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [N_W-1:0]     in_nx,
  input  logic [N_W-1:0]     in_ny,
  input  logic [D_W-1:0]     in_d,
  input  logic               in_negx,
  input  logic               in_negy,
  input  logic               in_coinc,
  output logic               out_valid,
  output logic [FORCE_W-1:0] out_fx,
  output logic [FORCE_W-1:0] out_fy,
  output logic               out_coinc
);

  logic           vld   [0:Q_BITS];
  div_lane_t      lx    [0:Q_BITS];
  div_lane_t      ly    [0:Q_BITS];
  logic [D_W-1:0] d     [0:Q_BITS];
  logic           coinc [0:Q_BITS];

  // Setup stage: overflow check and first remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx[0]    <= div_init(in_nx, in_negx, in_d);
      ly[0]    <= div_init(in_ny, in_negy, in_d);
      d[0]     <= in_d;
      coinc[0] <= in_coinc;
    end
  end

  // One quotient bit per stage on both axes.
  for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lx[k+1]    <= div_step(lx[k], k, d[k]);
        ly[k+1]    <= div_step(ly[k], k, d[k]);
        d[k+1]     <= d[k];
        coinc[k+1] <= coinc[k];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_fx    <= force_out(lx[Q_BITS], coinc[Q_BITS]);
      out_fy    <= force_out(ly[Q_BITS], coinc[Q_BITS]);
      out_coinc <= coinc[Q_BITS];
    end
  end

endmodule

/* test/tb_gravity_pair_force_top.sv */
// Testbench for the pairwise gravity force engine: directed and random pairs, scored per beat.
module tb_gravity_pair_force_top import gpf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int LONG_HOLD      = 400;
  localparam logic [FORCE_W-1:0] FORCE_POS_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] FORCE_NEG_MAX = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POS_W-1:0]  src_x;
    logic signed [POS_W-1:0]  src_y;
    logic        [MASS_W-1:0] src_mass;
    logic signed [POS_W-1:0]  tgt_x;
    logic signed [POS_W-1:0]  tgt_y;
    logic        [MASS_W-1:0] tgt_mass;
    logic                     is_source;
  } body_pair_t;

  typedef struct packed {
    logic [FORCE_W-1:0] fx;
    logic [FORCE_W-1:0] fy;
    logic               coinc;
  } pull_t;

  typedef struct packed {
    body_pair_t pair;
    logic       typed;
    pull_t      pull;
  } pair_row_t;

  typedef enum int {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_e;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  gpf_pair_if  req_if();
  gpf_force_if rsp_if();

  gravity_pair_force_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req(req_if), .rsp(rsp_if)
  );

  // Model copy of the constant register and the queue of pulls still owed.
  logic [GRAV_W-1:0] grav_model;
  pull_t             pull_q[$];
  logic              beat_typed;
  pull_t             beat_pull;
  idle_mode_e        idle_mode;
  bit                hold_request;
  int                mismatches;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Force along one axis: sign of the offset, floor of the magnitude, saturated.
  function automatic logic [FORCE_W-1:0] axis_pull(logic [255:0] base, logic [255:0] den,
                                                   logic signed [33:0] d);
    logic [255:0] mag;
    logic [255:0] q;
    mag = d[33] ? 256'(-d) : 256'(d);
    q   = (base * mag) / den;
    if (d[33]) begin
      if (q > 256'(1) << 47) return FORCE_NEG_MAX;
      return FORCE_W'(-q);
    end
    if (q > 256'(FORCE_POS_MAX)) return FORCE_POS_MAX;
    return FORCE_W'(q);
  endfunction

  // Newtonian pull on the target toward the source, in exact integer arithmetic.
  function automatic pull_t pair_pull(body_pair_t p, logic [GRAV_W-1:0] g);
    logic signed [33:0] dx, dy;
    logic [255:0]       ax, ay, sum, root, trial, den, base;
    pull_t              r;
    dx = {{2{p.src_x[31]}}, p.src_x} - {{2{p.tgt_x[31]}}, p.tgt_x};
    dy = {{2{p.src_y[31]}}, p.src_y} - {{2{p.tgt_y[31]}}, p.tgt_y};
    r = '0;
    if (dx == 0 && dy == 0) begin
      r.coinc = 1'b1;
      return r;
    end
    ax  = dx[33] ? 256'(-dx) : 256'(dx);
    ay  = dy[33] ? 256'(-dy) : 256'(dy);
    sum = ax * ax + ay * ay;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      trial = root | (256'(1) << b);
      if (trial * trial <= sum) root = trial;
    end
    den  = (sum * root) << GRAV_SHIFT;
    base = ((256'(g) * 256'(p.src_mass)) * 256'(p.tgt_mass)) << (3 * POS_FRAC_BITS);
    r.fx = axis_pull(base, den, dx);
    r.fy = axis_pull(base, den, dy);
    return r;
  endfunction

  // Random pair: half nearby bodies with mixed masses, some coincident and self pairs.
  function automatic body_pair_t random_pair();
    body_pair_t p;
    int         kind;
    kind = $urandom_range(0, 19);
    p.src_x = $urandom;
    p.src_y = $urandom;
    p.src_mass = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 1000)) : $urandom;
    p.tgt_mass = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 1000)) : $urandom;
    if ($urandom_range(0, 29) == 0) p.src_mass = '0;
    if (kind < 8) begin
      p.tgt_x = $urandom;
      p.tgt_y = $urandom;
    end else if (kind < 18) begin
      p.tgt_x = p.src_x + 32'($signed(16'($urandom)));
      p.tgt_y = p.src_y + 32'($signed(16'($urandom)));
    end else begin
      p.tgt_x = p.src_x;
      p.tgt_y = p.src_y;
    end
    p.is_source = ($urandom_range(0, 9) == 0);
    return p;
  endfunction

  // Register write over the APB port; the model copy follows at the write edge.
  task automatic write_grav(logic [GRAV_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * CFG_GRAV_CONST);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    grav_model = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one pair and hold it until the beat is taken; idle cycles come before it in a run of random length.
  task automatic send_pair(body_pair_t p, logic typed, pull_t pull);
    int gap;
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SEND_LIGHT) ? 30 :
               (idle_mode == IDLE_RECV_LIGHT) ? 67 : 0;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.src_x     <= p.src_x;
    req_if.src_y     <= p.src_y;
    req_if.src_mass  <= p.src_mass;
    req_if.tgt_x     <= p.tgt_x;
    req_if.tgt_y     <= p.tgt_y;
    req_if.tgt_mass  <= p.tgt_mass;
    req_if.is_source <= p.is_source;
    beat_typed       <= typed;
    beat_pull        <= pull;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pull_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls by mode, and a long counted hold on request.
  initial begin
    int hold_left;
    int stall_pct;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      stall_pct = (idle_mode == IDLE_SEND_LIGHT) ? 67 :
                  (idle_mode == IDLE_RECV_LIGHT) ? 30 : 0;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Scoreboard: predict on each accepted pair, compare each accepted result.
  always @(posedge clk) begin
    pull_t want;
    if (!rst && req_if.valid && req_if.ready && !req_if.is_source) begin
      if (beat_typed) pull_q.push_back(beat_pull);
      else pull_q.push_back(pair_pull({req_if.src_x, req_if.src_y, req_if.src_mass,
                                       req_if.tgt_x, req_if.tgt_y, req_if.tgt_mass,
                                       req_if.is_source}, grav_model));
    end
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pull_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: fx=%h fy=%h coinc=%b",
                                       rsp_if.force_x, rsp_if.force_y, rsp_if.coincident);
      end else begin
        want = pull_q.pop_front();
        if (rsp_if.force_x !== want.fx || rsp_if.force_y !== want.fy ||
            rsp_if.coincident !== want.coinc) begin
          mismatches++;
          if (mismatches <= 10)
            $display("force mismatch: exp fx=%h fy=%h coinc=%b, got fx=%h fy=%h coinc=%b",
                     want.fx, want.fy, want.coinc,
                     rsp_if.force_x, rsp_if.force_y, rsp_if.coincident);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either stream.
  always @(posedge clk) begin
    int quiet;
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    pair_row_t        rows[$];
    pair_row_t        row;
    logic [GRAV_W-1:0] grav_steps[5];
    pull_t            none;
    none = '0;
    mismatches = 0;
    hold_request = 1'b0;
    idle_mode = IDLE_SEND_LIGHT;
    grav_model = 32'd1;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_if.valid = 1'b0; req_if.src_x = '0; req_if.src_y = '0; req_if.src_mass = '0;
    req_if.tgt_x = '0; req_if.tgt_y = '0; req_if.tgt_mass = '0; req_if.is_source = 1'b0;
    beat_typed = 1'b0; beat_pull = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, run with the constant at its reset value.
    rows.push_back('{'{32'sd5, 32'sd7, 32'd9, 32'sd5, 32'sd7, 32'd9, 1'b0}, 1'b1, '{0, 0, 1'b1}});
    rows.push_back('{'{32'h80000000, 32'h80000000, '1, 32'h80000000, 32'h80000000, '1, 1'b0},
                     1'b1, '{0, 0, 1'b1}});
    rows.push_back('{'{32'sd1, 32'sd2, 32'd3, 32'sd4, 32'sd5, 32'd6, 1'b1}, 1'b0, none});
    rows.push_back('{'{32'h7fffffff, 32'h7fffffff, '1, 32'h80000000, 32'h80000000, '1, 1'b1},
                     1'b0, none});
    rows.push_back('{'{32'sd100, 32'sd0, 32'd0, 32'sd0, 32'sd0, 32'd50, 1'b0},
                     1'b1, '{0, 0, 1'b0}});
    rows.push_back('{'{32'sd0, 32'sd100, 32'd50, 32'sd0, 32'sd0, 32'd0, 1'b0},
                     1'b1, '{0, 0, 1'b0}});
    rows.push_back('{'{32'sd1, 32'sd0, '1, 32'sd0, 32'sd0, '1, 1'b0},
                     1'b1, '{FORCE_POS_MAX, 0, 1'b0}});
    rows.push_back('{'{32'sd0, 32'sd0, '1, 32'sd1, 32'sd0, '1, 1'b0},
                     1'b1, '{FORCE_NEG_MAX, 0, 1'b0}});
    rows.push_back('{'{32'sd0, 32'sd1, '1, 32'sd0, 32'sd0, '1, 1'b0},
                     1'b1, '{0, FORCE_POS_MAX, 1'b0}});
    rows.push_back('{'{32'sd0, 32'sd0, '1, 32'sd0, 32'sd1, '1, 1'b0},
                     1'b1, '{0, FORCE_NEG_MAX, 1'b0}});
    rows.push_back('{'{32'h7fffffff, 32'h7fffffff, '1, 32'h80000000, 32'h80000000, '1, 1'b0},
                     1'b0, none});
    rows.push_back('{'{32'h80000000, 32'h7fffffff, '1, 32'h7fffffff, 32'h80000000, '1, 1'b0},
                     1'b0, none});
    rows.push_back('{'{32'sd65536, 32'sd0, 32'd1, 32'sd0, 32'sd0, 32'd1, 1'b0}, 1'b0, none});
    rows.push_back('{'{32'sd0, 32'sd0, 32'd1000, 32'sd196608, -32'sd262144, 32'd1, 1'b0},
                     1'b0, none});
    rows.push_back('{'{-32'sd3, 32'sd4, 32'd1, 32'sd0, 32'sd0, 32'd1, 1'b0}, 1'b0, none});
    foreach (rows[i]) begin
      row = rows[i];
      send_pair(row.pair, row.typed, row.pull);
    end

    // Random phases, each under its own constant; the register is written while drained.
    grav_steps[0] = 32'd1;
    grav_steps[1] = 32'hffffffff;
    grav_steps[2] = 32'd0;
    grav_steps[3] = $urandom;
    grav_steps[4] = 32'h00010000;
    for (int ph = 0; ph < 5; ph++) begin
      idle_mode = (ph < 2) ? IDLE_SEND_LIGHT : (ph < 4) ? IDLE_RECV_LIGHT : IDLE_NONE;
      if (ph > 0) begin
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_grav(grav_steps[ph]);
      end
      for (int n = 0; n < 400; n++) begin
        // Back-pressure: the receiver holds while pairs keep coming.
        if (ph == 4 && n == 20) hold_request = 1'b1;
        // Sender pause until every owed pull has come back.
        if (ph == 4 && n == 300) wait_drained();
        send_pair(random_pair(), 1'b0, none);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pull_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
